### rtl/xec_pkg.sv
package xec_pkg;

    localparam int NUM_ENT    = 5;
    localparam int ENT_MAX    = 6;
    localparam int HOLD_DEPTH = 5;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_cnt;

    // One unit of output work: up to six bytes, first byte in lane 0
    typedef struct packed {
        logic [ENT_MAX-1:0][7:0] bytes;
        t_cnt                    count;
    } t_job;

    localparam t_byte ENT_TEXT [NUM_ENT][ENT_MAX] = '{
        '{"&", "q", "u", "o", "t", ";"},
        '{"&", "a", "p", "o", "s", ";"},
        '{"&", "l", "t", ";", 8'h00, 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00},
        '{"&", "a", "m", "p", ";", 8'h00}
    };

    localparam t_cnt ENT_LEN [NUM_ENT] = '{3'd6, 3'd6, 3'd4, 3'd4, 3'd5};

    localparam t_byte ENT_CHAR [NUM_ENT] = '{8'h22, 8'h27, "<", ">", "&"};

    localparam logic MODE_ESCAPE   = 1'b0;
    localparam logic MODE_UNESCAPE = 1'b1;

endpackage

### rtl/xec_front.sv
module xec_front
    import xec_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_valid,
    input  logic  i_cfg_data,
    input  logic  i_accept,
    input  t_byte i_data_byte,
    input  logic  i_string_end,
    output logic  o_push,
    output t_job  o_job
);

    logic  r_mode;
    t_cnt  r_held_cnt;
    t_cnt  n_held_cnt;
    t_byte r_held [HOLD_DEPTH];

    t_byte cand [ENT_MAX];
    logic  any_full;
    logic  any_pre;
    logic  esc_hit;
    logic  m;
    logic  hold_ext;
    logic  hold_amp;
    int    full_idx;
    int    esc_idx;

    // Build the candidate text: held prefix followed by the new byte
    always_comb begin
        for (int k = 0; k < ENT_MAX; k++) begin
            cand[k] = (t_cnt'(k) == r_held_cnt) ? i_data_byte : 8'h00;
        end
        for (int k = 0; k < HOLD_DEPTH; k++) begin
            if (t_cnt'(k) < r_held_cnt) begin
                cand[k] = r_held[k];
            end
        end
    end

    // Match the candidate against every entity at once
    always_comb begin
        any_full = 1'b0;
        any_pre  = 1'b0;
        full_idx = 0;
        m        = 1'b0;
        for (int i = 0; i < NUM_ENT; i++) begin
            m = (r_held_cnt < ENT_LEN[i]);
            for (int k = 0; k < ENT_MAX; k++) begin
                if (t_cnt'(k) <= r_held_cnt && cand[k] != ENT_TEXT[i][k]) begin
                    m = 1'b0;
                end
            end
            if (m && (r_held_cnt + 3'd1 == ENT_LEN[i])) begin
                any_full = 1'b1;
                full_idx = i;
            end
            if (m && (r_held_cnt + 3'd1 < ENT_LEN[i])) begin
                any_pre = 1'b1;
            end
        end
    end

    // Look up the byte among the special characters
    always_comb begin
        esc_hit = 1'b0;
        esc_idx = 0;
        for (int i = 0; i < NUM_ENT; i++) begin
            if (i_data_byte == ENT_CHAR[i]) begin
                esc_hit = 1'b1;
                esc_idx = i;
            end
        end
    end

    // Classify the beat into a job and the next hold state
    always_comb begin
        o_job.bytes = '0;
        o_job.count = 3'd0;
        n_held_cnt  = 3'd0;
        hold_ext    = 1'b0;
        hold_amp    = 1'b0;
        if (r_mode == MODE_ESCAPE) begin
            if (esc_hit) begin
                for (int k = 0; k < ENT_MAX; k++) begin
                    o_job.bytes[k] = ENT_TEXT[esc_idx][k];
                end
                o_job.count = ENT_LEN[esc_idx];
            end else begin
                o_job.bytes[0] = i_data_byte;
                o_job.count    = 3'd1;
            end
        end else begin
            for (int k = 0; k < ENT_MAX; k++) begin
                o_job.bytes[k] = cand[k];
            end
            if (any_full) begin
                o_job.bytes    = '0;
                o_job.bytes[0] = ENT_CHAR[full_idx];
                o_job.count    = 3'd1;
            end else if (any_pre) begin
                if (i_string_end || r_held_cnt == 3'(HOLD_DEPTH)) begin
                    o_job.count = r_held_cnt + 3'd1;
                end else begin
                    hold_ext   = 1'b1;
                    n_held_cnt = r_held_cnt + 3'd1;
                end
            end else if (i_data_byte == "&" && !i_string_end) begin
                // flush the held text, then start a new hold
                o_job.count = r_held_cnt;
                hold_amp    = 1'b1;
                n_held_cnt  = 3'd1;
            end else begin
                o_job.count = r_held_cnt + 3'd1;
            end
        end
    end

    assign o_push = i_accept && (o_job.count != 3'd0);

    // Hold mode and held count; a mode write drops the hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ESCAPE;
            r_held_cnt <= 3'd0;
        end else if (i_cfg_valid) begin
            r_mode     <= i_cfg_data;
            r_held_cnt <= 3'd0;
        end else if (i_accept) begin
            r_held_cnt <= n_held_cnt;
        end
    end

    // Store held bytes
    always_ff @(posedge i_clk) begin
        if (i_accept && hold_ext) begin
            r_held[r_held_cnt] <= i_data_byte;
        end else if (i_accept && hold_amp) begin
            r_held[0] <= i_data_byte;
        end
    end

endmodule

### rtl/xec_queue.sv
module xec_queue
    import xec_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_head_job = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

### rtl/xec_back.sv
module xec_back
    import xec_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_empty,
    input  t_job  i_head_job,
    output logic  o_pop,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_byte o_out_byte,
    output logic  o_run_last
);

    logic                    r_valid;
    t_cnt                    r_left;
    logic [ENT_MAX-1:0][7:0] r_bytes;
    logic                    out_acc;
    logic                    free;

    assign out_acc     = r_valid && !i_out_stall;
    assign free        = !r_valid || (out_acc && r_left == 3'd1);
    assign o_pop       = free && !i_empty;
    assign o_out_valid = r_valid;
    assign o_out_byte  = r_bytes[0];
    assign o_run_last  = (r_left == 3'd1);

    // Load the next job or advance through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= 3'd0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_left  <= i_head_job.count;
        end else if (out_acc) begin
            r_valid <= (r_left != 3'd1);
            r_left  <= r_left - 3'd1;
        end
    end

    // Shift the bytes toward lane 0
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes <= i_head_job.bytes;
        end else if (out_acc) begin
            r_bytes <= r_bytes >> 8;
        end
    end

endmodule

### rtl/xml_entity_codec_top.sv
// XML predefined entity codec, escape and unescape over a byte stream.
// Input channel: i_in_valid / o_in_stall, carrying i_data_byte and
// i_string_end (last byte of a string). A beat is taken when valid is high
// and stall is low. Output channel: o_out_valid / i_out_stall, carrying
// o_out_byte and o_run_last, which marks the last byte produced by one input.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the mode bit
// (0 escape, 1 unescape); a write also drops any held partial entity.
// Write config only while the block is drained.
// An accepted beat passes the job queue, then the output register.
// Throughput: one input per cycle while the queue is not full; the output
// shifter sends one byte per cycle while i_out_stall is low, so the bytes
// of an escaped character's entity leave one after another. Inputs that only
// extend a held prefix produce nothing.
// A job queue of QUEUE_DEPTH entries sits between classifier and output;
// o_in_stall rises when it fills, so an output stall backs up to the input.
// Reset (synchronous, active low) selects escape mode and empties the hold,
// the queue and the output register.
module xml_entity_codec_top
    import xec_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_string_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic accept;
    logic push;
    logic full;
    logic pop;
    logic empty;
    t_job push_job;
    t_job head_job;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    xec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_string_end (i_string_end),
        .o_push       (push),
        .o_job        (push_job)
    );

    xec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_head_job (head_job)
    );

    xec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head_job  (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

endmodule

### tb/tb_xml_entity_codec_top.sv
`timescale 1ns / 100ps

module tb_xml_entity_codec_top;
    import xec_pkg::*;

    // Entity indexes and classification codes for the prediction
    localparam int N_ENT      = 5;
    localparam int ENT_QUOT   = 0;
    localparam int ENT_APOS   = 1;
    localparam int ENT_LT     = 2;
    localparam int ENT_GT     = 3;
    localparam int ENT_AMP    = 4;
    localparam int CLS_NONE   = 5;
    localparam int CLS_PREFIX = 6;
    localparam int HOLD_MAX   = 5;

    localparam logic [7:0] AMP_CHAR = 8'h26;

    // Cycles to let pass after the last result before a mode write or the end
    localparam int DRAIN_CYCLES = 4;
    // Cycles with no accepted beat on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_beat;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_data  = MODE_ESCAPE;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_end    = 1'b0;
    logic       out_stall = 1'b0;

    logic       cfg_ready;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       run_last;

    // Predictor state: mode shadow and the held entity prefix
    logic       mode_now = MODE_ESCAPE;
    int         held_cnt = 0;
    logic [7:0] held_buf [0:HOLD_MAX-1];
    logic [7:0] cand_buf [0:HOLD_MAX];

    t_out_beat  expected_out [$];
    t_out_beat  got_beat;

    logic       idle_enable = 1'b1;
    int         stall_left  = 0;
    int         idle_cycles = 0;
    int         errors      = 0;
    int         items_sent  = 0;
    int         results_seen = 0;
    int         cfg_writes  = 0;

    xml_entity_codec_top DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_data_byte  (in_byte),
        .i_string_end (in_end),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_byte   (out_byte),
        .o_run_last   (run_last)
    );

    always #10 clk = ~clk;

    // Entity text, length and character by index
    function automatic logic [7:0] entity_byte(input int idx, input int k);
        logic [47:0] s;
        case (idx)
            ENT_QUOT: s = "&quot;";
            ENT_APOS: s = "&apos;";
            ENT_LT:   s = {"&lt;", 16'h0000};
            ENT_GT:   s = {"&gt;", 16'h0000};
            default:  s = {"&amp;", 8'h00};
        endcase
        return s[47 - 8*k -: 8];
    endfunction

    function automatic int entity_len(input int idx);
        case (idx)
            ENT_QUOT, ENT_APOS: return 6;
            ENT_LT, ENT_GT:     return 4;
            default:            return 5;
        endcase
    endfunction

    function automatic logic [7:0] entity_char(input int idx);
        case (idx)
            ENT_QUOT: return 8'h22;
            ENT_APOS: return 8'h27;
            ENT_LT:   return 8'h3C;
            ENT_GT:   return 8'h3E;
            ENT_AMP:  return AMP_CHAR;
            default:  return 8'h00;
        endcase
    endfunction

    // Classify the first n candidate bytes: entity index, prefix or none
    function automatic int classify_candidate(input int n);
        int  i;
        int  k;
        bit  same;
        bit  prefix;
        prefix = 1'b0;
        for (i = 0; i < N_ENT; i++) begin
            if (n <= entity_len(i)) begin
                same = 1'b1;
                for (k = 0; k < n; k++)
                    if (cand_buf[k] != entity_byte(i, k))
                        same = 1'b0;
                if (same) begin
                    if (n == entity_len(i))
                        return i;
                    prefix = 1'b1;
                end
            end
        end
        return prefix ? CLS_PREFIX : CLS_NONE;
    endfunction

    function automatic void push_char(input logic [7:0] ch);
        t_out_beat beat;
        beat.ch   = ch;
        beat.last = 1'b0;
        expected_out.push_back(beat);
    endfunction

    // Work out the bytes one input beat produces and advance the hold
    function automatic void predict_codec(input logic [7:0] b, input logic str_end);
        int n_before;
        int cls;
        int i;
        n_before = expected_out.size();
        if (mode_now == MODE_ESCAPE) begin
            cls = CLS_NONE;
            for (i = 0; i < N_ENT; i++)
                if (entity_char(i) == b)
                    cls = i;
            if (cls == CLS_NONE)
                push_char(b);
            else
                for (i = 0; i < entity_len(cls); i++)
                    push_char(entity_byte(cls, i));
        end else begin
            for (i = 0; i < held_cnt; i++)
                cand_buf[i] = held_buf[i];
            cand_buf[held_cnt] = b;
            if (held_cnt == 0)
                cls = (b == AMP_CHAR) ? CLS_PREFIX : CLS_NONE;
            else
                cls = classify_candidate(held_cnt + 1);
            if (cls < N_ENT) begin
                push_char(entity_char(cls));
                held_cnt = 0;
            end else if (cls == CLS_PREFIX) begin
                if (str_end || held_cnt + 1 > HOLD_MAX) begin
                    for (i = 0; i <= held_cnt; i++)
                        push_char(cand_buf[i]);
                    held_cnt = 0;
                end else begin
                    held_buf[held_cnt] = b;
                    held_cnt = held_cnt + 1;
                end
            end else begin
                // mismatch: release the hold, then take the byte afresh
                for (i = 0; i < held_cnt; i++)
                    push_char(cand_buf[i]);
                held_cnt = 0;
                if (b == AMP_CHAR && !str_end) begin
                    held_buf[0] = b;
                    held_cnt = 1;
                end else begin
                    push_char(b);
                end
            end
        end
        if (expected_out.size() > n_before)
            expected_out[expected_out.size() - 1].last = 1'b1;
    endfunction

    // Send one input beat, with an occasional idle burst ahead of it
    task automatic send_char(input logic [7:0] b, input logic str_end);
        int gap;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_end   <= str_end;
        do @(posedge clk); while (in_stall);
        predict_codec(b, str_end);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic end_on_last);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i], end_on_last && (i == s.len() - 1));
    endtask

    // Drop valid, wait for every expected byte, then let the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_now = m;
        held_cnt = 0;
        cfg_writes++;
    endtask

    // Escape-mode token: mostly plain bytes, a third special characters
    task automatic send_escape_token();
        logic [7:0] b;
        if ($urandom_range(0, 2) == 0)
            b = entity_char($urandom_range(0, N_ENT - 1));
        else
            b = 8'($urandom_range(1, 255));
        send_char(b, $urandom_range(0, 7) == 0);
    endtask

    // Unescape-mode token: half whole entities, the rest broken ones and noise
    task automatic send_entity_token();
        int         pick;
        int         idx;
        int         n;
        int         k;
        logic [7:0] b;
        pick = $urandom_range(0, 9);
        idx  = $urandom_range(0, N_ENT - 1);
        b    = 8'($urandom_range(1, 255));
        if (pick <= 4) begin
            n = entity_len(idx);
            for (k = 0; k < n; k++)
                send_char(entity_byte(idx, k), (k == n - 1) ? ($urandom_range(0, 3) == 0)
                                                            : ($urandom_range(0, 15) == 0));
        end else if (pick == 5) begin
            n = $urandom_range(1, entity_len(idx) - 1);
            for (k = 0; k < n; k++)
                send_char(entity_byte(idx, k), 1'b0);
            send_char(b, $urandom_range(0, 7) == 0);
        end else if (pick == 6) begin
            send_char(AMP_CHAR, $urandom_range(0, 7) == 0);
        end else if (pick == 7) begin
            send_char(entity_char(idx), $urandom_range(0, 7) == 0);
        end else begin
            send_char(b, $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic test_escape_specials();
        send_text("\"'<>&a", 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("<", 1'b1);
    endtask

    task automatic test_unescape_edges();
        write_mode(MODE_UNESCAPE);
        // second ampersand restarts the match
        send_text("&&lt;", 1'b0);
        // string end on a byte that would extend the hold
        send_text("&q", 1'b1);
        send_text("&", 1'b1);
        // zero byte breaks a hold
        send_char(AMP_CHAR, 1'b0);
        send_char(8'h00, 1'b0);
        // complete entity on the string end
        send_text("&gt;", 1'b1);
    endtask

    task automatic test_mode_write_drops_hold();
        send_text("&am", 1'b0);
        write_mode(MODE_UNESCAPE);
        send_text("p;", 1'b0);
    endtask

    task automatic test_random_escape();
        write_mode(MODE_ESCAPE);
        while (items_sent < 50)
            send_escape_token();
    endtask

    task automatic test_random_unescape();
        write_mode(MODE_UNESCAPE);
        while (items_sent < 115)
            send_entity_token();
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        write_mode(MODE_UNESCAPE);
        while (items_sent < 135)
            send_entity_token();
        write_mode(MODE_ESCAPE);
        while (items_sent < 150)
            send_escape_token();
        wait_drained();
    endtask

    // Output side: random stall bursts while idle_enable is set
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 13);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Compare each output beat with the oldest expected byte
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_out.size() == 0) begin
                $error("unexpected output beat: out_byte %h run_last %b", out_byte, run_last);
                errors++;
            end else begin
                got_beat = expected_out.pop_front();
                if (out_byte !== got_beat.ch) begin
                    $error("out_byte: expected %h, got %h", got_beat.ch, out_byte);
                    errors++;
                end
                if (run_last !== got_beat.last) begin
                    $error("run_last: expected %b, got %b", got_beat.last, run_last);
                    errors++;
                end
            end
        end
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_escape_specials();
        test_unescape_edges();
        test_mode_write_drops_hold();
        test_random_escape();
        test_random_unescape();
        test_back_to_back();
        $display("covered %0d input bytes, %0d output bytes, %0d mode writes",
                 items_sent, results_seen, cfg_writes);
        $display("escape and unescape with stalls, broken entities and string ends");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
rtl/xec_pkg.sv
rtl/xec_front.sv
rtl/xec_queue.sv
rtl/xec_back.sv
rtl/xml_entity_codec_top.sv
tb/tb_xml_entity_codec_top.sv
